>>> sv/bds_pkg.sv
package bds_pkg;

	localparam int CHAN_W   = 8;
	localparam int PAIR_W   = CHAN_W + 1;
	localparam int NUM_CHAN = 4;
	localparam int CFG_W    = 13;
	localparam int COL_W    = 12;
	localparam int ROW_W    = 12;

	localparam logic [CFG_W-1:0] ROW_LIMIT     = 13'd4096;
	localparam logic [ROW_W-1:0] OUT_ROW_LIMIT = 12'd2048;

	typedef enum logic [1:0] {
		REG_ROW_PIXELS   = 2'd0,
		REG_OUT_COLS     = 2'd1,
		REG_OUT_ROWS     = 2'd2,
		REG_NUM_CHANNELS = 2'd3
	} reg_idx_t;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;
	typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_t;

	typedef struct packed {
		logic [CFG_W-1:0] row_len;
		logic [11:0]      out_cols;
		logic [CFG_W-1:0] src_rows;
		logic [2:0]       nch;
	} cfg_t;

	typedef struct packed {
		logic  vld;
		pair_t pairs;
		logic  frame_end;
	} issue_t;

endpackage

>>> sv/bds_if.sv
interface bds_pix_if;
	import bds_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] chan0;
	logic [CHAN_W-1:0] chan1;
	logic [CHAN_W-1:0] chan2;
	logic [CHAN_W-1:0] chan3;

	modport source (output valid, chan0, chan1, chan2, chan3, input ready);
	modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface bds_avg_if;
	import bds_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] avg0;
	logic [CHAN_W-1:0] avg1;
	logic [CHAN_W-1:0] avg2;
	logic [CHAN_W-1:0] avg3;
	logic              frame_end;

	modport source (output valid, avg0, avg1, avg2, avg3, frame_end, input ready);
	modport sink   (input valid, avg0, avg1, avg2, avg3, frame_end, output ready);
endinterface

>>> sv/bds_ram.sv
module bds_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/bds_front.sv
module bds_front
	import bds_pkg::*;
#(
	parameter int MAX_OUT_COLS = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bds_pix_if.sink                           src,
	input  cfg_t                              cfg,
	input  logic                              issue_ready,
	output issue_t                            issue,
	output logic                              ram_we,
	output logic                              ram_re,
	output logic [$clog2(MAX_OUT_COLS)-1:0]   ram_addr,
	output logic [PAIR_W*MAX_CHANNELS-1:0]    ram_wdata
);

	localparam int AW = $clog2(MAX_OUT_COLS);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pix_t             held_q;
	pix_t             pix;
	pair_t            pairs;
	logic [COL_W-2:0] k;
	logic             acc;
	logic             active;
	logic             pair_done;
	logic             row_end;
	logic             frame_wrap;

	assign src.ready = issue_ready;
	assign acc       = src.valid && issue_ready;
	assign pix       = {src.chan3, src.chan2, src.chan1, src.chan0};
	assign k         = col_q[COL_W-1:1];
	assign active    = {1'b0, k} < cfg.out_cols;
	assign pair_done = acc && active && col_q[0];

	always_comb begin
		pairs = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			pairs[i] = {1'b0, held_q[i]} + {1'b0, pix[i]};
		end
	end

	always_comb begin
		ram_wdata = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			ram_wdata[i*PAIR_W +: PAIR_W] = pairs[i];
		end
	end

	assign ram_we   = pair_done && !row_q[0];
	assign ram_re   = pair_done && row_q[0];
	assign ram_addr = AW'(k);

	assign issue.vld       = ram_re;
	assign issue.pairs     = pairs;
	assign issue.frame_end = ({1'b0, row_q} == cfg.src_rows - 13'd1) &&
		({1'b0, k} == cfg.out_cols - 12'd1);

	assign row_end    = ({1'b0, col_q} + 13'd1) >= cfg.row_len;
	assign frame_wrap = ({1'b0, row_q} + 13'd1) >= cfg.src_rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (acc) begin
			if (active && !col_q[0]) begin
				held_q <= pix;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_wrap ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

>>> sv/bds_avg.sv
module bds_avg
	import bds_pkg::*;
#(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  issue_t                         issue,
	input  logic [PAIR_W*MAX_CHANNELS-1:0] ram_rdata,
	input  logic [2:0]                     nch,
	output logic                           issue_ready,
	bds_avg_if.source                      dst
);

	logic   v_s1;
	issue_t iss_s1;
	logic   s1_adv;
	logic   out_valid_q;
	pix_t   avg_q;
	logic   fe_q;
	pix_t   avg;

	assign s1_adv      = v_s1 && (!out_valid_q || dst.ready);
	assign issue_ready = !v_s1 || s1_adv;

	// stored row pair plus current row pair, then divide by four
	always_comb begin
		logic [PAIR_W:0] sum;
		avg = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			sum = {1'b0, ram_rdata[i*PAIR_W +: PAIR_W]} + {1'b0, iss_s1.pairs[i]};
			if (3'(i) < nch) begin
				avg[i] = sum[PAIR_W:2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue.vld) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue.vld) begin
			iss_s1 <= issue;
		end
		if (s1_adv) begin
			avg_q <= avg;
			fe_q  <= iss_s1.frame_end;
		end
	end

	assign dst.valid     = out_valid_q;
	assign dst.avg0      = avg_q[0];
	assign dst.avg1      = avg_q[1];
	assign dst.avg2      = avg_q[2];
	assign dst.avg3      = avg_q[3];
	assign dst.frame_end = fe_q;

endmodule

>>> sv/box_downscale_2x2_top.sv
// A source pair is registered in the issue stage and then in the output register.
// Throughput: one source pixel per cycle unless the output stalls; separate read
// and write line store ports let even rows write pair sums while odd rows read.
// Reset: arst_n clears counters, held pixel and valids, and sets the configuration
// registers to defaults; the line store is not cleared, each even row writes it.
module box_downscale_2x2_top
	import bds_pkg::*;
#(
	parameter int MAX_OUT_COLS = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	bds_pix_if.sink          src,
	bds_avg_if.source        dst
);

	localparam int AW = $clog2(MAX_OUT_COLS);
	localparam int DW = PAIR_W * MAX_CHANNELS;

	logic [CFG_W-1:0] row_pixels_q;
	logic [11:0]      out_cols_q;
	logic [11:0]      out_rows_q;
	logic [2:0]       num_channels_q;

	cfg_t             cfg;
	issue_t           issue;
	logic             issue_ready;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_addr;
	logic [DW-1:0]    ram_wdata;
	logic [DW-1:0]    ram_rdata;
	logic [11:0]      rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q   <= 13'd2;
			out_cols_q     <= 12'd1;
			out_rows_q     <= 12'd1;
			num_channels_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_ROW_PIXELS:   row_pixels_q   <= cfg_data;
				REG_OUT_COLS:     out_cols_q     <= cfg_data[11:0];
				REG_OUT_ROWS:     out_rows_q     <= cfg_data[11:0];
				REG_NUM_CHANNELS: num_channels_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_pixels_q == '0) begin
			cfg.row_len = 13'd1;
		end else if (row_pixels_q > ROW_LIMIT) begin
			cfg.row_len = ROW_LIMIT;
		end else begin
			cfg.row_len = row_pixels_q;
		end

		if (out_cols_q == '0) begin
			cfg.out_cols = 12'd1;
		end else if (32'(out_cols_q) > MAX_OUT_COLS) begin
			cfg.out_cols = 12'(MAX_OUT_COLS);
		end else begin
			cfg.out_cols = out_cols_q;
		end

		if (out_rows_q == '0) begin
			rows_eff = 12'd1;
		end else if (out_rows_q > OUT_ROW_LIMIT) begin
			rows_eff = OUT_ROW_LIMIT;
		end else begin
			rows_eff = out_rows_q;
		end
		cfg.src_rows = {rows_eff, 1'b0};

		if (32'(num_channels_q) > MAX_CHANNELS) begin
			cfg.nch = 3'(MAX_CHANNELS);
		end else begin
			cfg.nch = num_channels_q;
		end
	end

	bds_front #(
		.MAX_OUT_COLS(MAX_OUT_COLS),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.cfg        (cfg),
		.issue_ready(issue_ready),
		.issue      (issue),
		.ram_we     (ram_we),
		.ram_re     (ram_re),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata)
	);

	bds_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_OUT_COLS)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	bds_avg #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.ram_rdata  (ram_rdata),
		.nch        (cfg.nch),
		.issue_ready(issue_ready),
		.dst        (dst)
	);

endmodule

>>> sv/bds_chk.sv
module bds_chk
	import bds_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_ready,
	input logic              dst_valid,
	input logic              dst_ready,
	input logic [CHAN_W-1:0] dst_avg0,
	input logic              dst_frame_end
);

	// a stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_avg0) && $stable(dst_frame_end))
		else $error("result changed while stalled");

	// input only backs up behind a waiting result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> dst_valid)
		else $error("input stalled with no result waiting");

	// a fresh result follows a source transaction through the issue and output registers
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(src_valid && src_ready, 2))
		else $error("result without source transaction");

endmodule

bind box_downscale_2x2_top bds_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.src_valid    (src.valid),
	.src_ready    (src.ready),
	.dst_valid    (dst.valid),
	.dst_ready    (dst.ready),
	.dst_avg0     (dst.avg0),
	.dst_frame_end(dst.frame_end)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import bds_pkg::*;

	localparam int LINE_DEPTH    = 2048;
	localparam int MAX_NCH       = 4;
	localparam int IDLE_LIMIT    = 5000;
	localparam int RANDOM_PIXELS = 700;
	localparam int PRINT_LIMIT   = 40;

	typedef struct packed {
		pix_t avg;
		logic frame_end;
	} avg_px_t;

	class box_avg_board;
		logic [CFG_W-1:0] row_pixels;
		logic [11:0]      out_cols;
		logic [11:0]      out_rows;
		logic [2:0]       num_channels;
		pair_t            pair_sums [LINE_DEPTH];
		pix_t             left_px;
		int unsigned      col;
		int unsigned      row;
		avg_px_t          due_avgs [$];
		int               errors;
		int               taken;

		function new();
			row_pixels   = 13'd2;
			out_cols     = 12'd1;
			out_rows     = 12'd1;
			num_channels = 3'd4;
			left_px      = '0;
			col          = 0;
			row          = 0;
			errors       = 0;
			taken        = 0;
		endfunction

		function int unsigned row_len();
			if (row_pixels < 1)
				return 1;
			if (row_pixels > ROW_LIMIT)
				return ROW_LIMIT;
			return row_pixels;
		endfunction

		function int unsigned cols_eff();
			if (out_cols == 0)
				return 1;
			if (out_cols > LINE_DEPTH)
				return LINE_DEPTH;
			return out_cols;
		endfunction

		function int unsigned rows_eff();
			if (out_rows == 0)
				return 1;
			if (out_rows > OUT_ROW_LIMIT)
				return OUT_ROW_LIMIT;
			return out_rows;
		endfunction

		function bit at_frame_start();
			return col == 0 && row == 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_ROW_PIXELS:   row_pixels   = val;
				REG_OUT_COLS:     out_cols     = val[11:0];
				REG_OUT_ROWS:     out_rows     = val[11:0];
				REG_NUM_CHANNELS: num_channels = val[2:0];
				default: ;
			endcase
		endfunction

		function void take_pixel(pix_t px);
			int unsigned     oc, src_rows, k, nch;
			int              i;
			pair_t           sum2;
			logic [PAIR_W:0] sum4;
			avg_px_t         res;
			oc       = cols_eff();
			src_rows = 2 * rows_eff();
			taken++;
			if ((col >> 1) < oc) begin
				if (col % 2 == 0) begin
					left_px = px;
				end else begin
					k = col >> 1;
					for (i = 0; i < NUM_CHAN; i++)
						sum2[i] = {1'b0, left_px[i]} + {1'b0, px[i]};
					if (row % 2 == 0) begin
						pair_sums[k] = sum2;
					end else begin
						nch = (num_channels > MAX_NCH) ? MAX_NCH : num_channels;
						for (i = 0; i < NUM_CHAN; i++) begin
							sum4 = {1'b0, pair_sums[k][i]} + {1'b0, sum2[i]};
							res.avg[i] = (i < nch) ? sum4[PAIR_W:2] : '0;
						end
						res.frame_end = (row == src_rows - 1) && (k == oc - 1);
						due_avgs.push_back(res);
					end
				end
			end
			if (col + 1 >= row_len()) begin
				col = 0;
				row = (row + 1 >= src_rows) ? 0 : ((row + 1) & 12'hFFF);
			end else begin
				col = (col + 1) & 12'hFFF;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("[%0t] %s", $time, msg);
		endtask

		task match_avg(avg_px_t got);
			avg_px_t want;
			int      i;
			if (due_avgs.size() == 0) begin
				report($sformatf("output transaction %h with nothing expected", got));
				return;
			end
			want = due_avgs.pop_front();
			for (i = 0; i < NUM_CHAN; i++) begin
				if (got.avg[i] !== want.avg[i])
					report($sformatf("avg%0d got %h want %h", i, got.avg[i], want.avg[i]));
			end
			if (got.frame_end !== want.frame_end)
				report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	bds_pix_if src_if();
	bds_avg_if dst_if();

	box_avg_board board;
	int hold_req     = 0;
	bit tx_calm      = 0;
	int tx_calm_left = 0;
	int rx_calm_left = 0;
	int idle_cycles  = 0;

	box_downscale_2x2_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.src      (src_if),
		.dst      (dst_if)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly back to back, some short gaps, the odd long one, and calm stretches
	function automatic int idle_gap(ref int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 2) begin
			calm_left = $urandom_range(40, 200);
			return 0;
		end
		if (r < 120)
			return 0;
		if (r < 180)
			return $urandom_range(1, 3);
		if (r < 196)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic pix_t rand_pix();
		pix_t px;
		int   i, r;
		for (i = 0; i < NUM_CHAN; i++) begin
			r = $urandom_range(0, 9);
			px[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
		end
		return px;
	endfunction

	task automatic send_pixel(pix_t px);
		int gap;
		gap = tx_calm ? 0 : idle_gap(tx_calm_left);
		if (gap != 0) begin
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.chan0 <= px[0];
		src_if.chan1 <= px[1];
		src_if.chan2 <= px[2];
		src_if.chan3 <= px[3];
		@(posedge clk);
		while (!src_if.ready)
			@(posedge clk);
		board.take_pixel(px);
	endtask

	task automatic finish_frame();
		while (!board.at_frame_start())
			send_pixel(rand_pix());
	endtask

	// drain: pixels with no result may still be in the pipe when the queue empties
	task automatic settle();
		src_if.valid <= 1'b0;
		while (board.due_avgs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] rp, logic [CFG_W-1:0] oc,
			logic [CFG_W-1:0] rows, logic [CFG_W-1:0] nch);
		reg_idx_t         idx [4];
		logic [CFG_W-1:0] val [4];
		int               i;
		idx = '{REG_ROW_PIXELS, REG_OUT_COLS, REG_OUT_ROWS, REG_NUM_CHANNELS};
		val = '{rp, oc, rows, nch};
		cfg_we <= 1'b1;
		for (i = 0; i < 4; i++) begin
			cfg_idx  <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			board.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : rx_side
		int wait_left;
		wait_left = 0;
		dst_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				wait_left = hold_req;
				hold_req  = 0;
			end else if (wait_left == 0) begin
				wait_left = idle_gap(rx_calm_left);
			end
			if (wait_left != 0) begin
				dst_if.ready <= 1'b0;
				wait_left--;
			end else begin
				dst_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_if.valid && dst_if.ready)
			board.match_avg({dst_if.avg3, dst_if.avg2, dst_if.avg1, dst_if.avg0,
				dst_if.frame_end});
	end

	always @(posedge clk) begin
		if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int               start, r, half;
		logic [CFG_W-1:0] rp, oc, rows, nch;
		board = new();
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_idx      <= REG_ROW_PIXELS;
		cfg_data     <= '0;
		src_if.valid <= 1'b0;
		src_if.chan0 <= '0;
		src_if.chan1 <= '0;
		src_if.chan2 <= '0;
		src_if.chan3 <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: one 2x2 block per frame
		repeat (4) send_pixel({4{8'hFF}});
		repeat (4) send_pixel('0);
		repeat (2) begin
			send_pixel({4{8'hAA}});
			send_pixel({4{8'h55}});
		end
		// truncation of the quarter
		send_pixel({8'hFE, 8'h00, 8'hFF, 8'h01});
		send_pixel({8'hFF, 8'h01, 8'hFF, 8'h01});
		send_pixel({8'hFF, 8'h01, 8'hFF, 8'h00});
		send_pixel({8'hFF, 8'h01, 8'hFF, 8'h01});
		settle();
		configure(13'd2, 13'd1, 13'd1, 13'd2);
		repeat (4) send_pixel({4{8'hFF}});
		settle();
		configure(13'd2, 13'd1, 13'd1, 13'd0);
		repeat (4) send_pixel({4{8'hFF}});

		// every pixel ends its row
		settle();
		configure(13'd0, 13'd1, 13'd1, 13'd4);
		repeat (9) send_pixel(rand_pix());
		finish_frame();
		settle();
		configure(13'd1, 13'd3, 13'd2, 13'd4);
		repeat (7) send_pixel(rand_pix());
		finish_frame();
		// short rows, frame_end stays low
		settle();
		configure(13'd6, 13'd5, 13'd2, 13'd4);
		repeat (30) send_pixel(rand_pix());
		finish_frame();

		// wide frame; sink holds off during the odd row so the input backs up
		settle();
		configure(13'd96, 13'd48, 13'd1, 13'd4);
		tx_calm = 1'b1;
		repeat (100) send_pixel(rand_pix());
		hold_req = 400;
		finish_frame();
		tx_calm = 1'b0;
		// saturated row length and width, upper data bits ignored
		settle();
		configure(13'h1FFF, 13'h0FFF, 13'h1001, 13'd7);
		repeat (20) send_pixel(rand_pix());
		// tallest frame, zero width taken as one
		settle();
		configure(13'd2, 13'h1000, 13'h0FFF, 13'd5);
		repeat (20) send_pixel(rand_pix());

		start = board.taken;
		while (board.taken - start < RANDOM_PIXELS) begin
			settle();
			if (board.at_frame_start()) begin
				r  = $urandom_range(0, 19);
				rp = (r == 0) ? 13'($urandom_range(0, 1)) : 13'($urandom_range(2, 16));
				half = rp / 2;
				r = $urandom_range(0, 9);
				if (r == 0)
					oc = '0;
				else if (r == 1 || half == 0)
					oc = 13'($urandom_range(1, rp + 2));
				else
					oc = 13'($urandom_range(1, half));
			end else begin
				// mid-frame: never widen, so odd rows only read pair sums already stored
				rp = 13'($urandom_range(0, board.row_len()));
				oc = 13'($urandom_range(0, board.cols_eff()));
			end
			oc[12]   = 1'($urandom);
			rows     = 13'($urandom_range(0, 4));
			rows[12] = 1'($urandom);
			nch      = 13'($urandom);
			configure(rp, oc, rows, nch);
			repeat ($urandom_range(1, 48)) send_pixel(rand_pix());
			if ($urandom_range(0, 4) != 0)
				finish_frame();
		end

		settle();
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
